@@ src/breakpoint_linear_interpolator_macros.svh @@
// assertion macros shared by the interpolator rtl
`ifndef BREAKPOINT_LINEAR_INTERPOLATOR_MACROS_SVH
`define BREAKPOINT_LINEAR_INTERPOLATOR_MACROS_SVH

// same-cycle implication, checked out of reset
`define BLI_ASSERT_IMPL(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define BLI_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/bli_pkg.sv @@
// shared types, constants and microcode table of the breakpoint interpolator
`timescale 1ns / 1ps
package bli_pkg;

  localparam int DATA_W          = 32;
  localparam int IDX_W           = 6;
  localparam int CFG_W           = 7;
  localparam int STAT_W          = 2;
  localparam int DEF_TABLE_DEPTH = 64;
  localparam int DIV_STEPS       = DATA_W;
  localparam int CNT_W           = $clog2(DIV_STEPS);

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  localparam logic [STAT_W-1:0] ST_INTERP = 2'd0;
  localparam logic [STAT_W-1:0] ST_LOW    = 2'd1;
  localparam logic [STAT_W-1:0] ST_HIGH   = 2'd2;
  localparam logic [STAT_W-1:0] ST_FAULT  = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FIRST,
    S_LASTCHK,
    S_SCAN,
    S_ADV,
    S_NOINT,
    S_SETUP,
    S_MUL,
    S_DIVINIT,
    S_DIV,
    S_INTERP,
    S_LOW,
    S_HIGH,
    S_ZERO,
    S_EMIT
  } step_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LD_PREV,
    OP_LD_CUR,
    OP_ADVANCE,
    OP_SETUP,
    OP_MUL,
    OP_DIVINIT,
    OP_DIVSTEP,
    OP_R_INTERP,
    OP_R_LOW,
    OP_R_HIGH,
    OP_R_NOINT,
    OP_R_ZERO,
    OP_EMIT
  } op_t;

  typedef enum logic [1:0] {
    RS_ZERO,
    RS_LAST,
    RS_KP1,
    RS_KP2
  } rsel_t;

  typedef enum logic [3:0] {
    C_ALWAYS,
    C_START,
    C_LE,
    C_GE,
    C_HIT,
    C_MORE,
    C_WZERO,
    C_DIVDONE,
    C_OFREE
  } cond_t;

  typedef struct packed {
    op_t   op;
    rsel_t rsel;
    cond_t cond;
    step_t target;
    logic  hold;
  } ctrl_t;

  typedef struct packed {
    logic start;
    logic le;
    logic ge;
    logic hit;
    logic more;
    logic wzero;
    logic div_done;
    logic ofree;
  } flags_t;

  typedef struct packed {
    logic [DATA_W-1:0] tm;
    logic [DATA_W-1:0] amp;
  } entry_t;

  function automatic ctrl_t mk_word(op_t op, rsel_t rs, cond_t c, step_t tgt, logic hold);
    ctrl_t w;
    w.op     = op;
    w.rsel   = rs;
    w.cond   = c;
    w.target = tgt;
    w.hold   = hold;
    return w;
  endfunction

  // control store: on a true condition jump to target, else hold or step on
  function automatic ctrl_t ucode(step_t s);
    ctrl_t w;
    unique case (s)
      S_IDLE:    w = mk_word(OP_NOP,      RS_ZERO, C_START,   S_FIRST, 1'b1);
      S_FIRST:   w = mk_word(OP_LD_PREV,  RS_LAST, C_LE,      S_LOW,   1'b0);
      S_LASTCHK: w = mk_word(OP_LD_CUR,   RS_KP1,  C_GE,      S_HIGH,  1'b0);
      S_SCAN:    w = mk_word(OP_LD_CUR,   RS_ZERO, C_HIT,     S_SETUP, 1'b0);
      S_ADV:     w = mk_word(OP_ADVANCE,  RS_KP2,  C_MORE,    S_SCAN,  1'b0);
      S_NOINT:   w = mk_word(OP_R_NOINT,  RS_ZERO, C_ALWAYS,  S_EMIT,  1'b0);
      S_SETUP:   w = mk_word(OP_SETUP,    RS_ZERO, C_ALWAYS,  S_MUL,   1'b0);
      S_MUL:     w = mk_word(OP_MUL,      RS_ZERO, C_WZERO,   S_ZERO,  1'b0);
      S_DIVINIT: w = mk_word(OP_DIVINIT,  RS_ZERO, C_ALWAYS,  S_DIV,   1'b0);
      S_DIV:     w = mk_word(OP_DIVSTEP,  RS_ZERO, C_DIVDONE, S_INTERP, 1'b1);
      S_INTERP:  w = mk_word(OP_R_INTERP, RS_ZERO, C_ALWAYS,  S_EMIT,  1'b0);
      S_LOW:     w = mk_word(OP_R_LOW,    RS_ZERO, C_ALWAYS,  S_EMIT,  1'b0);
      S_HIGH:    w = mk_word(OP_R_HIGH,   RS_ZERO, C_ALWAYS,  S_EMIT,  1'b0);
      S_ZERO:    w = mk_word(OP_R_ZERO,   RS_ZERO, C_ALWAYS,  S_EMIT,  1'b0);
      S_EMIT:    w = mk_word(OP_EMIT,     RS_ZERO, C_OFREE,   S_IDLE,  1'b1);
      default:   w = mk_word(OP_NOP,      RS_ZERO, C_ALWAYS,  S_IDLE,  1'b0);
    endcase
    return w;
  endfunction

endpackage

@@ src/bli_mem.sv @@
// breakpoint table memory, one write port and one registered read port
`timescale 1ns / 1ps
module bli_mem import bli_pkg::*; #(
  parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
  localparam int AW = $clog2(TABLE_DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  entry_t        wdata,
  input  logic [AW-1:0] raddr,
  output entry_t        rdata
);

  entry_t mem_r [TABLE_DEPTH];
  entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ src/bli_ctrl.sv @@
// microcode sequencer: step counter, control store lookup and jump logic
`timescale 1ns / 1ps
`include "breakpoint_linear_interpolator_macros.svh"
module bli_ctrl import bli_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  flags_t flags,
  output ctrl_t  cw,
  output step_t  pc
);

  step_t pc_r;
  step_t pc_nxt;
  logic  take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= S_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  // next step
  always_comb begin
    unique case (cw.cond)
      C_ALWAYS:  take = 1'b1;
      C_START:   take = flags.start;
      C_LE:      take = flags.le;
      C_GE:      take = flags.ge;
      C_HIT:     take = flags.hit;
      C_MORE:    take = flags.more;
      C_WZERO:   take = flags.wzero;
      C_DIVDONE: take = flags.div_done;
      C_OFREE:   take = flags.ofree;
      default:   take = 1'b0;
    endcase
    if (take) begin
      pc_nxt = cw.target;
    end else if (cw.hold) begin
      pc_nxt = pc_r;
    end else begin
      pc_nxt = step_t'(pc_r + 4'd1);
    end
  end

  // control word decode
  always_comb begin
    cw = ucode(pc_r);
    pc = pc_r;
  end

  `BLI_ASSERT_NEXT(a_query_enters_program, clk, rst_n, flags.start, pc_r == S_FIRST, "query did not start the program")
  `BLI_ASSERT_IMPL(a_idle_waits, clk, rst_n, (pc_r == S_IDLE) && !flags.start, pc_nxt == S_IDLE, "sequencer left idle without a query")
  `BLI_ASSERT_NEXT(a_emit_returns, clk, rst_n, (pc_r == S_EMIT) && flags.ofree, pc_r == S_IDLE, "emit step did not return to idle")

endmodule

@@ src/bli_dp.sv @@
// interpolation datapath: scan registers, multiplier, restoring divider, output register
`timescale 1ns / 1ps
`include "breakpoint_linear_interpolator_macros.svh"
module bli_dp import bli_pkg::*; #(
  parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
  localparam int AW = $clog2(TABLE_DEPTH)
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  ctrl_t                    cw,
  input  logic                     in_accept,
  input  logic                     in_kind,
  input  logic [IDX_W-1:0]         in_entry_index,
  input  logic [DATA_W-1:0]        in_time_value,
  input  logic signed [DATA_W-1:0] in_amp_value,
  input  logic                     cfg_we,
  input  logic [CFG_W-1:0]         cfg_wdata,
  input  logic                     out_stall,
  output flags_t                   flags,
  output logic                     mem_we,
  output logic [AW-1:0]            mem_waddr,
  output entry_t                   mem_wdata,
  output logic [AW-1:0]            mem_raddr,
  input  entry_t                   mem_rdata,
  output logic                     out_valid,
  output logic signed [DATA_W-1:0] out_amplitude_out,
  output logic [STAT_W-1:0]        out_status
);

  localparam int MW = (CFG_W > AW + 1) ? CFG_W : AW + 1;
  localparam int PW = 2 * DATA_W;
  localparam logic [MW-1:0] DEPTH_M = MW'(TABLE_DEPTH);

  logic [CFG_W-1:0]  cfg_r;
  logic [DATA_W-1:0] tq_r;
  logic [AW-1:0]     k_r;
  entry_t            prev_r;
  entry_t            cur_r;
  logic [DATA_W-1:0] width_r;
  logic [DATA_W-1:0] offset_r;
  logic [DATA_W-1:0] mag_r;
  logic              neg_r;
  logic [PW-1:0]     prod_r;
  logic [DATA_W-1:0] rem_r;
  logic [DATA_W-1:0] quo_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [DATA_W-1:0] res_r;
  logic [STAT_W-1:0] stat_r;
  logic              out_valid_r;
  logic              out_valid_nxt;
  logic [DATA_W-1:0] out_amp_r;
  logic [STAT_W-1:0] out_stat_r;

  logic [MW-1:0]     pu_ext;
  logic [MW-1:0]     n_pts;
  logic [AW-1:0]     last_idx;
  logic [AW-1:0]     kp1;
  logic [AW-1:0]     kp2;
  logic [DATA_W:0]   delta;
  logic [DATA_W:0]   delta_mag;
  logic [DATA_W+1:0] trial;
  logic              div_ge;
  logic [DATA_W-1:0] res_interp;
  logic              ofree;
  logic              emit_go;

  // clamp of the point count to 1..depth
  always_comb begin
    pu_ext = MW'(cfg_r);
    if (pu_ext == '0) begin
      n_pts = MW'(1);
    end else if (pu_ext > DEPTH_M) begin
      n_pts = DEPTH_M;
    end else begin
      n_pts = pu_ext;
    end
    last_idx = AW'(n_pts - MW'(1));
    kp1      = k_r + AW'(1);
    kp2      = k_r + AW'(2);
  end

  always_comb begin
    case (cw.rsel)
      RS_ZERO: mem_raddr = '0;
      RS_LAST: mem_raddr = last_idx;
      RS_KP1:  mem_raddr = kp1;
      RS_KP2:  mem_raddr = kp2;
      default: mem_raddr = '0;
    endcase
  end

  always_comb begin
    mem_we        = in_accept && (in_kind == KIND_WRITE) && (MW'(in_entry_index) < DEPTH_M);
    mem_waddr     = AW'(in_entry_index);
    mem_wdata.tm  = in_time_value;
    mem_wdata.amp = in_amp_value;
  end

  always_comb begin
    delta      = {cur_r.amp[DATA_W-1], cur_r.amp} - {prev_r.amp[DATA_W-1], prev_r.amp};
    delta_mag  = delta[DATA_W] ? ((DATA_W+1)'(0) - delta) : delta;
    trial      = {1'b0, rem_r, quo_r[DATA_W-1]} - {2'b00, width_r};
    div_ge     = !trial[DATA_W+1];
    res_interp = neg_r ? (prev_r.amp - quo_r) : (prev_r.amp + quo_r);
    ofree      = !out_valid_r || !out_stall;
    emit_go    = (cw.op == OP_EMIT) && ofree;
  end

  always_comb begin
    flags.start    = in_accept && (in_kind == KIND_QUERY);
    flags.le       = tq_r <= mem_rdata.tm;
    flags.ge       = tq_r >= mem_rdata.tm;
    flags.hit      = (prev_r.tm <= tq_r) && (tq_r <= mem_rdata.tm);
    flags.more     = (MW'(k_r) + MW'(2)) < n_pts;
    flags.wzero    = width_r == '0;
    flags.div_done = cnt_r == CNT_W'(DIV_STEPS - 1);
    flags.ofree    = ofree;
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      tq_r <= in_time_value;
      k_r  <= '0;
    end
    case (cw.op)
      OP_LD_PREV: prev_r <= mem_rdata;
      OP_LD_CUR:  cur_r  <= mem_rdata;
      OP_ADVANCE: begin
        prev_r <= cur_r;
        k_r    <= kp1;
      end
      OP_SETUP: begin
        width_r  <= cur_r.tm - prev_r.tm;
        offset_r <= tq_r - prev_r.tm;
        mag_r    <= delta_mag[DATA_W-1:0];
        neg_r    <= delta[DATA_W];
      end
      OP_MUL: prod_r <= PW'(mag_r) * PW'(offset_r);
      OP_DIVINIT: begin
        rem_r <= prod_r[PW-1:DATA_W];
        quo_r <= prod_r[DATA_W-1:0];
        cnt_r <= '0;
      end
      OP_DIVSTEP: begin
        rem_r <= div_ge ? trial[DATA_W-1:0] : {rem_r[DATA_W-2:0], quo_r[DATA_W-1]};
        quo_r <= {quo_r[DATA_W-2:0], div_ge};
        cnt_r <= cnt_r + CNT_W'(1);
      end
      OP_R_INTERP: begin
        res_r  <= res_interp;
        stat_r <= ST_INTERP;
      end
      OP_R_LOW: begin
        res_r  <= prev_r.amp;
        stat_r <= ST_LOW;
      end
      OP_R_HIGH: begin
        res_r  <= cur_r.amp;
        stat_r <= ST_HIGH;
      end
      OP_R_NOINT: begin
        res_r  <= '0;
        stat_r <= ST_FAULT;
      end
      OP_R_ZERO: begin
        res_r  <= prev_r.amp;
        stat_r <= ST_FAULT;
      end
      default: ;
    endcase
    if (emit_go) begin
      out_amp_r  <= res_r;
      out_stat_r <= stat_r;
    end
  end

  assign out_valid_nxt = emit_go || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r       <= CFG_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        cfg_r <= cfg_wdata;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_amplitude_out = out_amp_r;
  assign out_status        = out_stat_r;

  `BLI_ASSERT_IMPL(a_div_rem_below, clk, rst_n, cw.op == OP_DIVSTEP, rem_r < width_r, "divider remainder not below divisor")
  `BLI_ASSERT_IMPL(a_scan_in_range, clk, rst_n, cw.op == OP_ADVANCE, (MW'(k_r) + MW'(1)) < n_pts, "scan ran past the last breakpoint")
  `BLI_ASSERT_IMPL(a_word_from_emit, clk, rst_n, $rose(out_valid_r), $past(cw.op == OP_EMIT), "result word appeared outside the emit step")

endmodule

@@ src/breakpoint_linear_interpolator.sv @@
// top level of the breakpoint linear interpolator
// usage:
//   input channel (in_valid / in_stall): a word with in_kind low writes one
//   breakpoint (in_entry_index, in_time_value, in_amp_value) and is taken
//   without a result; a word with in_kind high queries in_time_value.
//   result channel (out_valid / out_stall): one word per query, amplitude and status.
//   cfg_we / cfg_wdata set the number of breakpoints in use; write only while idle.
// sequencing:
//   a query clamped low or high skips the interval scan and the divider; the
//   interval scan reads the breakpoints in turn on the single table read port
//   and a query in an interval of nonzero width runs the 32-step restoring divider.
//   in_stall is high from acceptance of a query until its result sits in the
//   output register, so items are handled one at a time.
// reset: points in use returns to 1, the output register empties; table
//   contents stay undefined until written.
// a stalled result holds in the output register; the sequencer waits on it
//   before loading the next one.
`timescale 1ns / 1ps
module breakpoint_linear_interpolator import bli_pkg::*; #(
  parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     in_kind,
  input  logic [IDX_W-1:0]         in_entry_index,
  input  logic [DATA_W-1:0]        in_time_value,
  input  logic signed [DATA_W-1:0] in_amp_value,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [DATA_W-1:0] out_amplitude_out,
  output logic [STAT_W-1:0]        out_status,
  input  logic                     cfg_we,
  input  logic [CFG_W-1:0]         cfg_wdata
);

  localparam int AW = $clog2(TABLE_DEPTH);

  ctrl_t         cw;
  step_t         pc;
  flags_t        flags;
  logic          in_accept;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  entry_t        mem_wdata;
  logic [AW-1:0] mem_raddr;
  entry_t        mem_rdata;

  assign in_stall  = pc != S_IDLE;
  assign in_accept = in_valid && !in_stall;

  bli_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .flags (flags),
    .cw    (cw),
    .pc    (pc)
  );

  bli_mem #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  bli_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cw                (cw),
    .in_accept         (in_accept),
    .in_kind           (in_kind),
    .in_entry_index    (in_entry_index),
    .in_time_value     (in_time_value),
    .in_amp_value      (in_amp_value),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .out_stall         (out_stall),
    .flags             (flags),
    .mem_we            (mem_we),
    .mem_waddr         (mem_waddr),
    .mem_wdata         (mem_wdata),
    .mem_raddr         (mem_raddr),
    .mem_rdata         (mem_rdata),
    .out_valid         (out_valid),
    .out_amplitude_out (out_amplitude_out),
    .out_status        (out_status)
  );

endmodule

@@ test/breakpoint_linear_interpolator_checker.sv @@
// scoreboard for the breakpoint interpolator: breakpoint copy, answer prediction and compare
`timescale 1ns / 1ps
module breakpoint_linear_interpolator_checker import bli_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic                     in_stall,
  input  logic                     in_kind,
  input  logic [IDX_W-1:0]         in_entry_index,
  input  logic [DATA_W-1:0]        in_time_value,
  input  logic signed [DATA_W-1:0] in_amp_value,
  input  logic                     out_valid,
  input  logic                     out_stall,
  input  logic signed [DATA_W-1:0] out_amplitude_out,
  input  logic [STAT_W-1:0]        out_status,
  input  logic                     cfg_we,
  input  logic [CFG_W-1:0]         cfg_wdata,
  output int unsigned              mismatches,
  output int unsigned              answers_pending
);

  typedef struct packed {
    logic signed [DATA_W-1:0] amplitude;
    logic [STAT_W-1:0]        status;
  } answer_t;

  logic [DATA_W-1:0]        knot_time [DEF_TABLE_DEPTH];
  logic signed [DATA_W-1:0] knot_amp  [DEF_TABLE_DEPTH];
  logic [CFG_W-1:0]         points_reg;
  answer_t                  owed_q [$];
  answer_t                  want_ans;

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    mismatches++;
  endtask

  function automatic answer_t interpolate_at(input logic [DATA_W-1:0] t);
    int                n;
    int                k;
    logic [63:0]       width;
    logic [63:0]       offset;
    logic [63:0]       mag;
    logic [63:0]       quot;
    logic signed [63:0] a0;
    logic signed [63:0] a1;
    logic signed [63:0] delta;
    logic signed [63:0] sum;
    answer_t           ans;
    n = int'(points_reg);
    if (n < 1) n = 1;
    if (n > DEF_TABLE_DEPTH) n = DEF_TABLE_DEPTH;
    if (t <= knot_time[0]) begin
      ans.amplitude = knot_amp[0];
      ans.status    = ST_LOW;
      return ans;
    end
    if (t >= knot_time[n-1]) begin
      ans.amplitude = knot_amp[n-1];
      ans.status    = ST_HIGH;
      return ans;
    end
    ans.amplitude = '0;
    ans.status    = ST_FAULT;
    for (k = 0; k + 1 < n; k++) begin
      if (t >= knot_time[k] && t <= knot_time[k+1]) begin
        width = 64'(knot_time[k+1]) - 64'(knot_time[k]);
        // zero-width interval answers the left amplitude
        if (width == 0) begin
          ans.amplitude = knot_amp[k];
          return ans;
        end
        offset = 64'(t) - 64'(knot_time[k]);
        a0     = knot_amp[k];
        a1     = knot_amp[k+1];
        delta  = a1 - a0;
        mag    = (delta < 0) ? 64'(-delta) : 64'(delta);
        quot   = mag * offset / width;
        sum    = (delta < 0) ? a0 - $signed(quot) : a0 + $signed(quot);
        ans.amplitude = sum[DATA_W-1:0];
        ans.status    = ST_INTERP;
        return ans;
      end
    end
    return ans;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      points_reg = 7'd1;
      owed_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (owed_q.size() == 0) begin
          report_mismatch($sformatf("unexpected word amplitude %h status %0d",
                                    out_amplitude_out, out_status));
        end else begin
          want_ans = owed_q.pop_front();
          if (out_amplitude_out !== want_ans.amplitude)
            report_mismatch($sformatf("amplitude %h, predicted %h",
                                      out_amplitude_out, want_ans.amplitude));
          if (out_status !== want_ans.status)
            report_mismatch($sformatf("status %0d, predicted %0d",
                                      out_status, want_ans.status));
        end
      end
      if (cfg_we) points_reg = cfg_wdata;
      if (in_valid && !in_stall) begin
        if (in_kind == KIND_WRITE) begin
          knot_time[in_entry_index] = in_time_value;
          knot_amp[in_entry_index]  = in_amp_value;
        end else begin
          owed_q = {owed_q, interpolate_at(in_time_value)};
        end
      end
    end
    answers_pending = owed_q.size();
  end

endmodule

@@ test/breakpoint_linear_interpolator_tb.sv @@
// testbench top for the breakpoint interpolator: stimulus, backpressure and verdict
`timescale 1ns / 1ps
module breakpoint_linear_interpolator_tb;
  import bli_pkg::*;

  localparam int     ITEM_TARGET    = 950;
  localparam int     HOLDOFF_CYCLES = 400;
  localparam int     DRAIN_CYCLES   = 200;
  localparam int     CFG_GAP        = 4;
  localparam longint TIMEOUT_NS     = 16_000_000;

  logic                     clk = 1'b0;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_stall;
  logic                     in_kind;
  logic [IDX_W-1:0]         in_entry_index;
  logic [DATA_W-1:0]        in_time_value;
  logic signed [DATA_W-1:0] in_amp_value;
  logic                     out_valid;
  logic                     out_stall;
  logic signed [DATA_W-1:0] out_amplitude_out;
  logic [STAT_W-1:0]        out_status;
  logic                     cfg_we;
  logic [CFG_W-1:0]         cfg_wdata;

  int unsigned       mismatches;
  int unsigned       answers_pending;
  int                send_idle_pct;
  int                recv_idle_pct;
  int                holdoff_req;
  int                holdoff_seen;
  int                holdoff_left;
  int                items_sent;
  int                live_points;
  int                phase;
  logic [CFG_W-1:0]  points_pick;
  logic [DATA_W-1:0] knot_time_plan [DEF_TABLE_DEPTH];

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  breakpoint_linear_interpolator i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_kind           (in_kind),
    .in_entry_index    (in_entry_index),
    .in_time_value     (in_time_value),
    .in_amp_value      (in_amp_value),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_amplitude_out (out_amplitude_out),
    .out_status        (out_status),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata)
  );

  breakpoint_linear_interpolator_checker i_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_kind           (in_kind),
    .in_entry_index    (in_entry_index),
    .in_time_value     (in_time_value),
    .in_amp_value      (in_amp_value),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_amplitude_out (out_amplitude_out),
    .out_status        (out_status),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .mismatches        (mismatches),
    .answers_pending   (answers_pending)
  );

  // result side: random stalls plus one long hold-off
  initial begin
    out_stall    = 1'b0;
    holdoff_seen = 0;
    holdoff_left = 0;
    forever begin
      @(negedge clk);
      if (holdoff_seen != holdoff_req) begin
        holdoff_seen = holdoff_req;
        holdoff_left = HOLDOFF_CYCLES;
      end
      if (holdoff_left > 0) begin
        holdoff_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  initial begin
    #TIMEOUT_NS;
    $display("breakpoint_linear_interpolator_tb failed");
    $finish;
  end

  task automatic drive_word(input logic kind, input logic [IDX_W-1:0] slot,
                            input logic [DATA_W-1:0] tv, input logic [DATA_W-1:0] av);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_kind        <= kind;
    in_entry_index <= slot;
    in_time_value  <= tv;
    in_amp_value   <= av;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    items_sent++;
    if (kind == KIND_WRITE) knot_time_plan[slot] = tv;
  endtask

  task automatic query_at(input logic [DATA_W-1:0] tv);
    drive_word(KIND_QUERY, IDX_W'($urandom), tv, $urandom);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (answers_pending != 0) @(negedge clk);
  endtask

  task automatic set_points(input logic [CFG_W-1:0] v);
    wait_drained();
    repeat (CFG_GAP) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
    live_points = (v == 0) ? 1 : (v > DEF_TABLE_DEPTH) ? DEF_TABLE_DEPTH : int'(v);
  endtask

  // fill every slot in use; mostly ascending times, wide or tightly packed
  task automatic load_profile(input int style);
    logic [DATA_W-1:0] base;
    logic [DATA_W-1:0] key;
    logic [DATA_W-1:0] amp;
    int                i;
    int                j;
    base = $urandom;
    for (i = 0; i < live_points; i++) begin
      if (style % 2 == 0) knot_time_plan[i] = $urandom;
      else knot_time_plan[i] = base + $urandom_range(300);
    end
    if (style < 8) begin
      for (i = 1; i < live_points; i++) begin
        key = knot_time_plan[i];
        j   = i - 1;
        while (j >= 0 && knot_time_plan[j] > key) begin
          knot_time_plan[j+1] = knot_time_plan[j];
          j--;
        end
        knot_time_plan[j+1] = key;
      end
    end
    for (i = 0; i < live_points; i++) begin
      if ($urandom_range(1) == 1) amp = $urandom;
      else amp = 32'($urandom_range(32'h0004_0000)) - 32'h0002_0000;
      drive_word(KIND_WRITE, IDX_W'(i), knot_time_plan[i], amp);
    end
  endtask

  function automatic logic [DATA_W-1:0] pick_query_time();
    logic [DATA_W-1:0] lo;
    logic [DATA_W-1:0] hi;
    logic [63:0]       span;
    lo = knot_time_plan[0];
    hi = knot_time_plan[live_points-1];
    case ($urandom_range(9))
      0:       return $urandom;
      1:       return lo - $urandom_range(2);
      2:       return hi + $urandom_range(2);
      3, 4:    return knot_time_plan[$urandom_range(live_points-1)];
      default: begin
        if (hi <= lo) return $urandom;
        span = 64'(hi) - 64'(lo) + 1;
        return lo + 32'({$urandom, $urandom} % span);
      end
    endcase
  endfunction

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_kind        = KIND_WRITE;
    in_entry_index = '0;
    in_time_value  = '0;
    in_amp_value   = '0;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    send_idle_pct  = 20;
    recv_idle_pct  = 61;
    holdoff_req    = 0;
    items_sent     = 0;
    live_points    = 1;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    // single breakpoint, both clamps at the edges of the time range
    set_points(7'd1);
    drive_word(KIND_WRITE, 6'd0, 32'd1000, 32'h0001_0000);
    query_at(32'd0);
    query_at(32'd1000);
    query_at(32'd1001);
    query_at(32'hFFFF_FFFF);
    // zero points in use behaves as one
    set_points(7'd0);
    query_at(32'd500);
    query_at(32'd2000);
    // extreme times and amplitudes
    set_points(7'd3);
    drive_word(KIND_WRITE, 6'd0, 32'h0000_0000, 32'h8000_0000);
    drive_word(KIND_WRITE, 6'd1, 32'h8000_0000, 32'h7FFF_FFFF);
    drive_word(KIND_WRITE, 6'd2, 32'hFFFF_FFFF, 32'h8000_0000);
    query_at(32'd1);
    query_at(32'h8000_0000);
    query_at(32'hFFFF_FFFE);
    query_at(32'h0000_0000);
    query_at(32'hFFFF_FFFF);
    // descending times: low clamp takes priority over high clamp
    set_points(7'd2);
    drive_word(KIND_WRITE, 6'd0, 32'd500, 32'h1234_5678);
    drive_word(KIND_WRITE, 6'd1, 32'd100, 32'hFFFF_0000);
    query_at(32'd300);
    query_at(32'd600);
    // repeated breakpoint time
    set_points(7'd4);
    drive_word(KIND_WRITE, 6'd0, 32'd100, 32'hFFFD_0000);
    drive_word(KIND_WRITE, 6'd1, 32'd200, 32'h0005_0000);
    drive_word(KIND_WRITE, 6'd2, 32'd200, 32'h7FFF_0000);
    drive_word(KIND_WRITE, 6'd3, 32'd300, 32'h0000_8000);
    query_at(32'd200);
    query_at(32'd250);
    query_at(32'd150);

    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      if (items_sent >= 2 * ITEM_TARGET / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else if (items_sent >= ITEM_TARGET / 3) begin
        send_idle_pct = 61;
        recv_idle_pct = 20;
      end
      if (phase == 0) points_pick = 7'd127;
      else if (phase == 1) points_pick = 7'd64;
      else begin
        case ($urandom_range(9))
          0:       points_pick = 7'd0;
          1:       points_pick = 7'd1;
          2:       points_pick = 7'd64;
          3:       points_pick = $urandom_range(65, 127);
          4, 5, 6: points_pick = $urandom_range(2, 8);
          default: points_pick = $urandom_range(9, 63);
        endcase
      end
      set_points(points_pick);
      load_profile($urandom_range(9));
      if (phase == 2) holdoff_req++;
      repeat ($urandom_range(8, 30)) begin
        case ($urandom_range(19))
          0, 1:    drive_word(KIND_WRITE, IDX_W'($urandom_range(live_points-1)),
                              $urandom, $urandom);
          2:       wait_drained();
          default: query_at(pick_query_time());
        endcase
      end
      phase++;
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0) begin
      $display("breakpoint_linear_interpolator_tb passed");
    end else begin
      $display("breakpoint_linear_interpolator_tb failed");
    end
    $finish;
  end

endmodule
